/* src/ber_tlv_header_parser_assert.svh */
// ----------------------------------------------------------------------------
// BER TLV header parser assertion macros
// Clocked assertion shorthands with a synchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef BER_TLV_HEADER_PARSER_ASSERT_SVH
`define BER_TLV_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define BTLV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTLV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/btlv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV header parser package
// Shared widths, codes, state and result types for the parser.
// ----------------------------------------------------------------------------
package btlv_pkg;

  localparam int MAX_LEN_OCTETS = 8;
  localparam int TAG_BITS       = 32;
  localparam int LEN_BITS       = 64;
  localparam int OCT_CNT_BITS   = 4;

  localparam logic [7:0] ID_CLASS_MASK = 8'hC0;
  localparam logic [7:0] ID_CONS_MASK  = 8'h20;
  localparam logic [4:0] ID_HIGH_TAG   = 5'h1F;
  localparam logic [7:0] LEN_INDEF     = 8'h80;
  localparam logic [7:0] LEN_RESERVED  = 8'hFF;

  typedef enum logic [2:0] {
    PH_ID   = 3'd0,
    PH_TAG  = 3'd1,
    PH_LEN  = 3'd2,
    PH_LONG = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_CONTENT = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_LEN_OCTS = 2'd1,
    ERR_RESERVED = 2'd2,
    ERR_TAG_OVF  = 2'd3
  } err_t;

  typedef struct packed {
    phase_t                    phase;
    logic [1:0]                cls;
    logic                      cons;
    logic [TAG_BITS-1:0]       tag;
    logic [LEN_BITS-1:0]       len;
    logic [OCT_CNT_BITS-1:0]   octs_left;
    logic [LEN_BITS-1:0]       content_left;
  } parse_state_t;

  typedef struct packed {
    kind_t                 kind;
    logic [1:0]            tag_class;
    logic                  constructed;
    logic [31:0]           tag_number;
    logic [LEN_BITS-1:0]   content_length;
    logic                  indefinite;
    logic [7:0]            data_byte;
    logic                  last;
    err_t                  error_code;
  } result_t;

endpackage

/* src/btlv_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV header parser channel interfaces
// Valid/ready channels for input octets and parse results.
// ----------------------------------------------------------------------------
interface btlv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface btlv_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [1:0]                    tag_class;
  logic                          constructed;
  logic [31:0]                   tag_number;
  logic [btlv_pkg::LEN_BITS-1:0] content_length;
  logic                          indefinite;
  logic [7:0]                    data_byte;
  logic                          last;
  logic [1:0]                    error_code;

  modport source (output valid, output kind, output tag_class, output constructed,
                  output tag_number, output content_length, output indefinite,
                  output data_byte, output last, output error_code, input ready);
  modport sink   (input valid, input kind, input tag_class, input constructed,
                  input tag_number, input content_length, input indefinite,
                  input data_byte, input last, input error_code, output ready);
endinterface

/* src/ber_tlv_header_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV header parser
// Decodes BER identifier and length octets, then passes content octets.
// ----------------------------------------------------------------------------
//  channel   dir   handshake     payload
//  in_ch     in    valid/ready   in_byte (8)
//  out_ch    out   valid/ready   kind, tag_class, constructed, tag_number,
//                                content_length, indefinite, data_byte,
//                                last, error_code
//
//  One octet per cycle; a result is registered in the cycle after its octet.
//  The result register sets the rate: an octet is taken whenever the
//  register is empty or its item leaves in the same cycle.
//  Reset clears the parse phase and the result valid; no clearing pass.
//  A stall on out_ch holds in_ch ready low until the result is taken.
// ----------------------------------------------------------------------------
`include "ber_tlv_header_parser_assert.svh"

module ber_tlv_header_parser (
  input  logic       clk,
  input  logic       rst_n,
  btlv_in_if.sink    in_ch,
  btlv_out_if.source out_ch
);

  btlv_pkg::parse_state_t st_r;
  btlv_pkg::parse_state_t st_nxt;
  btlv_pkg::result_t      res_r;
  btlv_pkg::result_t      res_nxt;
  logic                   res_hit;
  logic                   out_valid_r;
  logic                   in_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  btlv_decode u_decode (
    .st        (st_r),
    .in_byte   (in_ch.in_byte),
    .st_nxt    (st_nxt),
    .res_valid (res_hit),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase  <= btlv_pkg::PH_ID;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r.phase  <= st_nxt.phase;
        out_valid_r <= res_hit;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_fire) begin
      st_r.cls          <= st_nxt.cls;
      st_r.cons         <= st_nxt.cons;
      st_r.tag          <= st_nxt.tag;
      st_r.len          <= st_nxt.len;
      st_r.octs_left    <= st_nxt.octs_left;
      st_r.content_left <= st_nxt.content_left;
      res_r             <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = res_r.kind;
  assign out_ch.tag_class      = res_r.tag_class;
  assign out_ch.constructed    = res_r.constructed;
  assign out_ch.tag_number     = res_r.tag_number;
  assign out_ch.content_length = res_r.content_length;
  assign out_ch.indefinite     = res_r.indefinite;
  assign out_ch.data_byte      = res_r.data_byte;
  assign out_ch.last           = res_r.last;
  assign out_ch.error_code     = res_r.error_code;

  `BTLV_ASSERT_NOW(a_err_back_to_id, clk, rst_n,
    out_valid_r && res_r.kind == btlv_pkg::KIND_ERROR,
    st_r.phase == btlv_pkg::PH_ID && res_r.error_code != btlv_pkg::ERR_NONE,
    "error item without return to identifier phase")
  `BTLV_ASSERT_NOW(a_content_open, clk, rst_n,
    out_valid_r && !res_r.last && res_r.kind != btlv_pkg::KIND_ERROR,
    st_r.phase == btlv_pkg::PH_DATA,
    "non-last item while no content is pending")
  `BTLV_ASSERT_NOW(a_long_count, clk, rst_n,
    st_r.phase == btlv_pkg::PH_LONG,
    st_r.octs_left != '0 &&
      st_r.octs_left <= btlv_pkg::OCT_CNT_BITS'(btlv_pkg::MAX_LEN_OCTETS),
    "length octet count out of range")
  `BTLV_ASSERT_NEXT(a_hold_on_stall, clk, rst_n,
    out_valid_r && !out_ch.ready,
    out_valid_r && $stable(st_r.phase),
    "parse state moved during output stall")

endmodule

/* src/btlv_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV octet decoder
// Next-state and result logic for one octet against the held parse state.
// ----------------------------------------------------------------------------
module btlv_decode (
  input  btlv_pkg::parse_state_t st,
  input  logic [7:0]             in_byte,
  output btlv_pkg::parse_state_t st_nxt,
  output logic                   res_valid,
  output btlv_pkg::result_t      res
);

  localparam int TagBits = btlv_pkg::TAG_BITS;
  localparam int LenBits = btlv_pkg::LEN_BITS;

  logic [LenBits-1:0]                 long_acc;
  logic [btlv_pkg::OCT_CNT_BITS-1:0]  octs_dec;
  logic [LenBits-1:0]                 content_dec;
  logic                               tag_ovf;
  logic                               len_too_many;
  btlv_pkg::phase_t                   phase_nxt;

  assign long_acc     = {st.len[LenBits-9:0], in_byte};
  assign octs_dec     = (st.octs_left != '0) ? st.octs_left - 1'b1 : st.octs_left;
  assign content_dec  = (st.content_left != '0) ? st.content_left - 1'b1
                                                : st.content_left;
  assign tag_ovf      = |st.tag[TagBits-1 -: 7];
  assign len_too_many = in_byte[6:0] > 7'(btlv_pkg::MAX_LEN_OCTETS);

  // phase
  always_comb begin
    phase_nxt = st.phase;
    unique case (st.phase)
      btlv_pkg::PH_ID: begin
        phase_nxt = (in_byte[4:0] == btlv_pkg::ID_HIGH_TAG) ? btlv_pkg::PH_TAG
                                                            : btlv_pkg::PH_LEN;
      end
      btlv_pkg::PH_TAG: begin
        if (tag_ovf) begin
          phase_nxt = btlv_pkg::PH_ID;
        end else if (!in_byte[7]) begin
          phase_nxt = btlv_pkg::PH_LEN;
        end
      end
      btlv_pkg::PH_LEN: begin
        priority if (!in_byte[7]) begin
          phase_nxt = (in_byte == 8'h00) ? btlv_pkg::PH_ID : btlv_pkg::PH_DATA;
        end else if (in_byte == btlv_pkg::LEN_INDEF || in_byte == btlv_pkg::LEN_RESERVED
                     || len_too_many) begin
          phase_nxt = btlv_pkg::PH_ID;
        end else begin
          phase_nxt = btlv_pkg::PH_LONG;
        end
      end
      btlv_pkg::PH_LONG: begin
        if (octs_dec == '0) begin
          phase_nxt = (long_acc == '0) ? btlv_pkg::PH_ID : btlv_pkg::PH_DATA;
        end
      end
      btlv_pkg::PH_DATA: begin
        if (content_dec == '0) begin
          phase_nxt = btlv_pkg::PH_ID;
        end
      end
      default: phase_nxt = btlv_pkg::PH_ID;
    endcase
  end

  // held fields and result
  always_comb begin
    st_nxt.phase        = phase_nxt;
    st_nxt.cls          = st.cls;
    st_nxt.cons         = st.cons;
    st_nxt.tag          = st.tag;
    st_nxt.len          = st.len;
    st_nxt.octs_left    = st.octs_left;
    st_nxt.content_left = st.content_left;
    res_valid           = 1'b0;
    res.kind            = btlv_pkg::KIND_HEADER;
    res.tag_class       = st.cls;
    res.constructed     = st.cons;
    res.tag_number      = 32'(st.tag);
    res.content_length  = '0;
    res.indefinite      = 1'b0;
    res.data_byte       = 8'h00;
    res.last            = 1'b0;
    res.error_code      = btlv_pkg::ERR_NONE;
    unique case (st.phase)
      btlv_pkg::PH_ID: begin
        st_nxt.cls          = in_byte[7:6];
        st_nxt.cons         = |(in_byte & btlv_pkg::ID_CONS_MASK);
        st_nxt.len          = '0;
        st_nxt.octs_left    = '0;
        st_nxt.content_left = '0;
        st_nxt.tag          = (in_byte[4:0] == btlv_pkg::ID_HIGH_TAG) ? '0
                                                                      : TagBits'(in_byte[4:0]);
      end
      btlv_pkg::PH_TAG: begin
        if (tag_ovf) begin
          res_valid      = 1'b1;
          res.kind       = btlv_pkg::KIND_ERROR;
          res.error_code = btlv_pkg::ERR_TAG_OVF;
        end else begin
          st_nxt.tag = {st.tag[TagBits-8:0], in_byte[6:0]};
        end
      end
      btlv_pkg::PH_LEN: begin
        priority if (!in_byte[7]) begin
          st_nxt.len          = LenBits'(in_byte);
          st_nxt.content_left = LenBits'(in_byte);
          res_valid           = 1'b1;
          res.content_length  = LenBits'(in_byte);
          res.last            = (in_byte == 8'h00);
        end else if (in_byte == btlv_pkg::LEN_INDEF) begin
          st_nxt.len     = '0;
          res_valid      = 1'b1;
          res.indefinite = 1'b1;
          res.last       = 1'b1;
        end else if (in_byte == btlv_pkg::LEN_RESERVED) begin
          res_valid      = 1'b1;
          res.kind       = btlv_pkg::KIND_ERROR;
          res.error_code = btlv_pkg::ERR_RESERVED;
        end else if (len_too_many) begin
          res_valid      = 1'b1;
          res.kind       = btlv_pkg::KIND_ERROR;
          res.error_code = btlv_pkg::ERR_LEN_OCTS;
        end else begin
          st_nxt.len       = '0;
          st_nxt.octs_left = in_byte[btlv_pkg::OCT_CNT_BITS-1:0];
        end
      end
      btlv_pkg::PH_LONG: begin
        st_nxt.len       = long_acc;
        st_nxt.octs_left = octs_dec;
        if (octs_dec == '0) begin
          st_nxt.content_left = long_acc;
          res_valid           = 1'b1;
          res.content_length  = long_acc;
          res.last            = (long_acc == '0);
        end
      end
      btlv_pkg::PH_DATA: begin
        st_nxt.content_left = content_dec;
        res_valid           = 1'b1;
        res.kind            = btlv_pkg::KIND_CONTENT;
        res.data_byte       = in_byte;
        res.last            = (content_dec == '0);
      end
      default: begin
      end
    endcase
  end

endmodule

/* tb/ber_tlv_header_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV header parser testbench
// Drives BER octet streams into the parser: fixed corner encodings first, then
// random TLV elements with random content, mixed with raw noise and broken
// tags. Each accepted octet goes through a cycle-free parse predictor. Every
// result is compared field by field against the oldest prediction. Sender and
// receiver pacing changes per phase, with a long receiver hold-off and a full
// drain pause.
// ----------------------------------------------------------------------------
module ber_tlv_header_parser_tb;
  import btlv_pkg::*;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int PHASE_OCTETS    = 300;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 8;

  class tlv_parse_checker;
    phase_t                  ph;
    logic [1:0]              cls;
    logic                    cons;
    logic [TAG_BITS-1:0]     tag;
    logic [LEN_BITS-1:0]     len_acc;
    logic [OCT_CNT_BITS-1:0] octs_left;
    logic [LEN_BITS-1:0]     body_left;
    result_t                 expected_results[$];
    int failures, checked, headers, contents, errors;

    function new();
      ph = PH_ID;
      cls = '0;
      cons = 1'b0;
      tag = '0;
      len_acc = '0;
      octs_left = '0;
      body_left = '0;
      failures = 0;
      checked = 0;
      headers = 0;
      contents = 0;
      errors = 0;
    endfunction

    function bit at_identifier();
      return ph == PH_ID;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // keep long-form lengths small: only the final octet may be nonzero
    function logic [7:0] tame_length_octet(input logic [7:0] b);
      if (ph == PH_LONG && !(octs_left == 1 && len_acc == '0)) return 8'h00;
      return b;
    endfunction

    function void note_octet(input logic [7:0] b);
      result_t r;
      bit emits;
      bit hdr;
      r = '0;
      emits = 1'b0;
      hdr = 1'b0;
      case (ph)
        PH_ID: begin
          cls = b[7:6];
          cons = b[5];
          len_acc = '0;
          octs_left = '0;
          body_left = '0;
          if (b[4:0] == ID_HIGH_TAG) begin
            tag = '0;
            ph = PH_TAG;
          end else begin
            tag = TAG_BITS'(b[4:0]);
            ph = PH_LEN;
          end
        end
        PH_TAG: begin
          if ((tag >> (TAG_BITS - 7)) != '0) begin
            r.kind = KIND_ERROR;
            r.error_code = ERR_TAG_OVF;
            emits = 1'b1;
            ph = PH_ID;
          end else begin
            tag = {tag[TAG_BITS-8:0], b[6:0]};
            if (!b[7]) ph = PH_LEN;
          end
        end
        PH_LEN: begin
          if (!b[7]) begin
            len_acc = LEN_BITS'(b);
            hdr = 1'b1;
          end else if (b == LEN_INDEF) begin
            len_acc = '0;
            ph = PH_ID;
            r.kind = KIND_HEADER;
            r.indefinite = 1'b1;
            r.last = 1'b1;
            emits = 1'b1;
          end else if (b == LEN_RESERVED) begin
            r.kind = KIND_ERROR;
            r.error_code = ERR_RESERVED;
            emits = 1'b1;
            ph = PH_ID;
          end else if (b[6:0] > MAX_LEN_OCTETS) begin
            r.kind = KIND_ERROR;
            r.error_code = ERR_LEN_OCTS;
            emits = 1'b1;
            ph = PH_ID;
          end else begin
            len_acc = '0;
            octs_left = b[OCT_CNT_BITS-1:0];
            ph = PH_LONG;
          end
        end
        PH_LONG: begin
          len_acc = {len_acc[LEN_BITS-9:0], b};
          if (octs_left > 0) octs_left--;
          if (octs_left == 0) hdr = 1'b1;
        end
        PH_DATA: begin
          if (body_left > 0) body_left--;
          r.kind = KIND_CONTENT;
          r.data_byte = b;
          r.last = (body_left == '0);
          emits = 1'b1;
          if (body_left == '0) ph = PH_ID;
        end
        default: ph = PH_ID;
      endcase
      if (hdr) begin
        body_left = len_acc;
        ph = (len_acc == '0) ? PH_ID : PH_DATA;
        r.kind = KIND_HEADER;
        r.content_length = len_acc;
        r.last = (len_acc == '0);
        emits = 1'b1;
      end
      if (emits) begin
        r.tag_class = cls;
        r.constructed = cons;
        r.tag_number = tag[31:0];
        expected_results.insert(expected_results.size(), r);
      end
    endfunction

    function int field_diff(input string name, input logic [63:0] want,
                            input logic [63:0] seen);
      if (want !== seen) begin
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, seen);
        return 1;
      end
      return 0;
    endfunction

    function void check_result(input result_t got);
      result_t want;
      int diffs;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, got kind %0d tag 0x%0h", $time,
                 got.kind, got.tag_number);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      diffs = 0;
      diffs += field_diff("kind", want.kind, got.kind);
      diffs += field_diff("tag_class", want.tag_class, got.tag_class);
      diffs += field_diff("constructed", want.constructed, got.constructed);
      diffs += field_diff("tag_number", want.tag_number, got.tag_number);
      diffs += field_diff("content_length", want.content_length, got.content_length);
      diffs += field_diff("indefinite", want.indefinite, got.indefinite);
      diffs += field_diff("data_byte", want.data_byte, got.data_byte);
      diffs += field_diff("last", want.last, got.last);
      diffs += field_diff("error_code", want.error_code, got.error_code);
      if (diffs != 0) failures++;
      checked++;
      case (want.kind)
        KIND_HEADER:  headers++;
        KIND_CONTENT: contents++;
        default:      errors++;
      endcase
    endfunction
  endclass

  logic clk;
  logic rst_n;

  btlv_in_if  in_ch();
  btlv_out_if out_ch();

  ber_tlv_header_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tlv_parse_checker sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int octets_sent = 0;

  logic [7:0] opening_octets[$] = '{
    8'h02, 8'h01, 8'hAB,
    8'h30, 8'h80,
    8'h9F, 8'h81, 8'h00, 8'hFF,
    8'hDF, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h81, 8'h00,
    8'h1F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
    8'h04, 8'h89,
    8'h24, 8'h81, 8'h02, 8'hAA, 8'h55
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_octet(input logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_octet(b);
    octets_sent++;
  endtask

  task automatic send_identifier(output bit broken);
    logic [63:0] tnum;
    logic [7:0] lead;
    int g;
    broken = 1'b0;
    lead = {2'($urandom_range(3)), 1'($urandom_range(1)), 5'd0};
    if ($urandom_range(9) < 5) begin
      send_octet(lead | 8'($urandom_range(30)));
      return;
    end
    if ($urandom_range(9) == 0)
      tnum = {24'd0, 8'($urandom_range(255, 1)), 32'($urandom)};
    else
      tnum = 64'($urandom) >> $urandom_range(31);
    send_octet(lead | {3'b000, ID_HIGH_TAG});
    if ($urandom_range(3) == 0) send_octet(8'h80);
    g = 1;
    while (g < 10 && (tnum >> (7 * g)) != 0) g++;
    for (int i = g - 1; i >= 0; i--) begin
      send_octet(8'((tnum >> (7 * i)) & 64'h7F) | ((i != 0) ? 8'h80 : 8'h00));
      // tag overflow: parser is back at the identifier, drop the rest
      if (sb.at_identifier()) begin
        broken = 1'b1;
        return;
      end
    end
  endtask

  task automatic send_length(input logic [63:0] len);
    int n;
    int pad;
    if (len < 128 && $urandom_range(1) == 1) begin
      send_octet(len[7:0]);
      return;
    end
    n = 1;
    while (n < MAX_LEN_OCTETS && (len >> (8 * n)) != 0) n++;
    pad = $urandom_range(MAX_LEN_OCTETS - n);
    send_octet(LEN_INDEF | 8'(n + pad));
    repeat (pad) send_octet(8'h00);
    for (int i = n - 1; i >= 0; i--) send_octet(len[8*i +: 8]);
  endtask

  task automatic send_element();
    bit broken;
    int pick;
    logic [63:0] len;
    send_identifier(broken);
    if (broken) return;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_octet(LEN_INDEF);
    end else if (pick < 12) begin
      send_octet(LEN_RESERVED);
    end else if (pick < 16) begin
      send_octet(8'($urandom_range(8'hFE, 8'h89)));
    end else begin
      len = (pick < 24) ? 64'($urandom_range(255)) : 64'($urandom_range(12));
      send_length(len);
      repeat (len) send_octet(8'($urandom));
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(6, 1);
    repeat (n) send_octet(sb.tame_length_octet(8'($urandom)));
    while (!sb.at_identifier()) send_octet(sb.tame_length_octet(8'($urandom)));
  endtask

  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : receiver
    int hold_left;
    result_t got;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.kind = kind_t'(out_ch.kind);
        got.tag_class = out_ch.tag_class;
        got.constructed = out_ch.constructed;
        got.tag_number = out_ch.tag_number;
        got.content_length = out_ch.content_length;
        got.indefinite = out_ch.indefinite;
        got.data_byte = out_ch.data_byte;
        got.last = out_ch.last;
        got.error_code = err_t'(out_ch.error_code);
        sb.check_result(got);
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int phase_start;
    bit held_off;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    out_ch.ready = 1'b0;
    held_off = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_octets[i]) send_octet(opening_octets[i]);
    pause_until_drained();

    for (int m = 0; m < 4; m++) begin
      case (m)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      phase_start = octets_sent;
      while (octets_sent - phase_start < PHASE_OCTETS) begin
        // hold the receiver off while the sender keeps offering items
        if (m == 0 && !held_off && octets_sent - phase_start > 100) begin
          hold_req = HOLD_OFF_CYCLES;
          held_off = 1'b1;
        end
        if ($urandom_range(99) < 8) send_noise();
        else send_element();
      end
      pause_until_drained();
    end

    // maximum definite length: parser stays in content for the rest of the run
    send_octet(8'h04);
    send_octet(LEN_INDEF | 8'(MAX_LEN_OCTETS));
    repeat (MAX_LEN_OCTETS) send_octet(8'hFF);
    repeat (16) send_octet(8'($urandom));
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d octets; checked %0d results: %0d headers, %0d content, %0d errors.",
             octets_sent, sb.checked, sb.headers, sb.contents, sb.errors);
    $display("Pacing: free-running, sender gaps, receiver stalls, both, plus a long hold-off.");
    if (sb.failures == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/btlv_pkg.sv
src/btlv_if.sv
src/btlv_decode.sv
src/ber_tlv_header_parser.sv
tb/ber_tlv_header_parser_tb.sv
